// File: rtl/nnsa_pkg.sv
// Shared types, constants and helpers for the nearest-neighbour scale addresser.
// No dependencies; imported by every module in rtl/.
package nnsa_pkg;

  // Dimension limits and default fraction width of the column accumulator
  localparam int MAX_DIM       = 4096;
  localparam int FRAC_BITS_DEF = 10;

  // Field widths
  localparam int COORD_W   = 12;
  localparam int REG_W     = 13;
  localparam int NUM_W     = COORD_W + REG_W;
  localparam int OFS_W     = 26;
  localparam int WORD_W    = 24;
  localparam int CFG_IDX_W = 8;

  // Configuration register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_SRC_WIDTH  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_SRC_HEIGHT = cfg_idx_t'(1);
  localparam cfg_idx_t REG_DST_WIDTH  = cfg_idx_t'(2);
  localparam cfg_idx_t REG_DST_HEIGHT = cfg_idx_t'(3);

  // Input item: destination pixel coordinate
  typedef struct packed {
    logic [COORD_W-1:0] dst_x;
    logic [COORD_W-1:0] dst_y;
  } pix_in_t;

  // Result item: sampled source pixel and addresses
  typedef struct packed {
    logic [COORD_W-1:0] src_col;
    logic [COORD_W-1:0] src_row;
    logic [OFS_W-1:0]   src_byte_offset;
    logic [WORD_W-1:0]  dst_word_index;
  } pix_out_t;

  // Fields carried alongside the row divider
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [WORD_W-1:0]  word;
    logic               y_in;
  } row_side_t;

  // Column step divider states
  typedef enum logic {
    SD_IDLE,
    SD_RUN
  } sdiv_state_e;

  // Zero reads as one, anything above the limit reads as the limit
  function automatic logic [REG_W-1:0] eff_dim(input logic [REG_W-1:0] v);
    logic [REG_W-1:0] r;
    if (v == '0) begin
      r = REG_W'(1);
    end else if (v > REG_W'(MAX_DIM)) begin
      r = REG_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: rtl/nnsa_step_div.sv
// Serial restoring divider for the column step (src_width << FRAC_BITS) / dst_width.
// Depends on nnsa_pkg.
module nnsa_step_div
  import nnsa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [REG_W-1:0]             dividend_i,
  input  logic [REG_W-1:0]             divisor_i,
  output logic                         busy_o,
  output logic [REG_W+FRAC_BITS-1:0]   quot_o
);

  localparam int STEP_W = REG_W + FRAC_BITS;
  localparam int CNT_W  = $clog2(STEP_W);

  sdiv_state_e       state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [REG_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0] quot_q, quot_d;
  logic [REG_W:0]    trial;
  logic              fits;

  // One quotient bit per cycle; dividend bits shift out as quotient bits shift in
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    trial   = {rem_q, quot_q[STEP_W-1]};
    fits    = trial >= {1'b0, divisor_i};
    unique case (state_q)
      SD_IDLE: begin
        if (start_i) begin
          state_d = SD_RUN;
          cnt_d   = CNT_W'(STEP_W - 1);
          rem_d   = '0;
          quot_d  = {dividend_i, {FRAC_BITS{1'b0}}};
        end
      end
      SD_RUN: begin
        // a fresh write restarts the division
        if (start_i) begin
          cnt_d  = CNT_W'(STEP_W - 1);
          rem_d  = '0;
          quot_d = {dividend_i, {FRAC_BITS{1'b0}}};
        end else begin
          rem_d  = fits ? REG_W'(trial - {1'b0, divisor_i}) : trial[REG_W-1:0];
          quot_d = {quot_q[STEP_W-2:0], fits};
          cnt_d  = cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_d = SD_IDLE;
          end
        end
      end
    endcase
  end

  // Quotient resets to the step for unit widths
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SD_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
      quot_q  <= STEP_W'(1) << FRAC_BITS;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      quot_q  <= quot_d;
    end
  end

  assign busy_o = (state_q == SD_RUN);
  assign quot_o = quot_q;

endmodule

// File: rtl/nnsa_row_div.sv
// Pipelined restoring divider for the source row, one quotient bit per stage.
// Depends on nnsa_pkg.
module nnsa_row_div
  import nnsa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [NUM_W-1:0]   num_i,
  input  row_side_t          side_i,
  input  logic [REG_W-1:0]   divisor_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [COORD_W-1:0] quot_o,
  output row_side_t          side_o
);

  localparam int STAGES = COORD_W;

  logic [STAGES-1:0]  v_q;
  logic [REG_W-1:0]   rem_q  [STAGES];
  logic [COORD_W-1:0] lo_q   [STAGES];
  logic [COORD_W-1:0] qt_q   [STAGES];
  row_side_t          side_q [STAGES];
  logic [STAGES:0]    rdy;

  // A stage takes new data when empty or when the next one moves
  assign rdy[STAGES] = ready_i;

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic               in_v;
    logic [REG_W-1:0]   in_rem;
    logic [COORD_W-1:0] in_lo;
    logic [COORD_W-1:0] in_qt;
    row_side_t          in_side;
    logic [REG_W:0]     trial;
    logic               fits;

    if (k == 0) begin : g_first
      // partial remainder starts with the upper numerator bits
      assign in_v    = valid_i;
      assign in_rem  = num_i[NUM_W-1:COORD_W];
      assign in_lo   = num_i[COORD_W-1:0];
      assign in_qt   = '0;
      assign in_side = side_i;
    end else begin : g_next
      assign in_v    = v_q[k-1];
      assign in_rem  = rem_q[k-1];
      assign in_lo   = lo_q[k-1];
      assign in_qt   = qt_q[k-1];
      assign in_side = side_q[k-1];
    end

    assign rdy[k] = !v_q[k] || rdy[k+1];
    assign trial  = {in_rem, in_lo[COORD_W-1]};
    assign fits   = trial >= {1'b0, divisor_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        rem_q[k]  <= fits ? REG_W'(trial - {1'b0, divisor_i}) : trial[REG_W-1:0];
        lo_q[k]   <= {in_lo[COORD_W-2:0], 1'b0};
        qt_q[k]   <= {in_qt[COORD_W-2:0], fits};
        side_q[k] <= in_side;
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[STAGES-1];
  assign quot_o  = qt_q[STAGES-1];
  assign side_o  = side_q[STAGES-1];

endmodule

// File: rtl/nearest_neighbor_scale_addresser_core.sv
// Top level of the nearest-neighbour scale addresser.
// Depends on nnsa_pkg, nnsa_step_div and nnsa_row_div.
//
// Takes one destination pixel (dst_x, dst_y) per clock when not stalled and
// returns the sampled source column and row, the byte offset of that pixel in a
// packed 3-byte RGB source buffer and the 24-bit destination word index. The
// datapath is 16 register stages: one multiply stage, one column accumulate
// and clamp stage, twelve row divider stages (one quotient bit each), one
// row-times-width stage and the output register. Each stage holds its item
// until the next one is free, so bubbles close up under output stall; with no
// stall, throughput stays at one item per clock. Writing src_width or dst_width
// starts a serial divider that forms the column step one bit per clock; the
// input is stalled from the registered write until the divider is done.
// Height writes take effect at once. cfg_ready_o is always high.
module nearest_neighbor_scale_addresser_core
  import nnsa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // item input
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pix_in_t          in_data_i,
  // result output
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pix_out_t         out_data_o,
  // register writes
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  cfg_idx_t         cfg_index_i,
  input  logic [REG_W-1:0] cfg_data_i
);

  localparam int STEP_W     = REG_W + FRAC_BITS;
  localparam int XS_W       = STEP_W + COORD_W;
  localparam int ACC_W      = XS_W + 1;
  localparam int COLR_W     = ACC_W - FRAC_BITS;
  localparam int SUM_W      = NUM_W + 1;
  localparam int OFS_FULL_W = SUM_W + 2;

  // Configuration registers, stored already clamped
  logic [REG_W-1:0] sw_q, sh_q, dw_q, dh_q;
  logic             start_q;
  logic             cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q    <= REG_W'(1);
      sh_q    <= REG_W'(1);
      dw_q    <= REG_W'(1);
      dh_q    <= REG_W'(1);
      start_q <= 1'b0;
    end else begin
      start_q <= cfg_wr && (cfg_index_i == REG_SRC_WIDTH || cfg_index_i == REG_DST_WIDTH);
      if (cfg_wr) begin
        unique case (cfg_index_i)
          REG_SRC_WIDTH:  sw_q <= eff_dim(cfg_data_i);
          REG_SRC_HEIGHT: sh_q <= eff_dim(cfg_data_i);
          REG_DST_WIDTH:  dw_q <= eff_dim(cfg_data_i);
          REG_DST_HEIGHT: dh_q <= eff_dim(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  // Column step, refreshed after a width write
  logic              sdiv_busy;
  logic [STEP_W-1:0] step;
  logic [REG_W-1:0]  col_start;

  nnsa_step_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_step_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_q),
    .dividend_i(sw_q),
    .divisor_i (dw_q),
    .busy_o    (sdiv_busy),
    .quot_o    (step)
  );

  // floor(step / 2^FRAC_BITS) equals floor(src_width / dst_width)
  assign col_start = step[STEP_W-1:FRAC_BITS];

  logic [REG_W-1:0] sw_last, sh_last;
  assign sw_last = sw_q - 1'b1;
  assign sh_last = sh_q - 1'b1;

  // Stage ready chain, output end first
  logic rdy1, rdy2, rdy3, rdy4, div_rdy;
  logic in_xfer;

  assign in_stall_o = !rdy1 || sdiv_busy || start_q;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Stage 1: products
  logic              v1_q;
  logic [NUM_W-1:0]  num1_q;
  logic [XS_W-1:0]   xs1_q;
  logic [WORD_W-1:0] word1_q;
  logic              yin1_q;
  logic [NUM_W-1:0]  word_full;

  assign rdy1      = !v1_q || rdy2;
  assign word_full = NUM_W'(in_data_i.dst_y) * NUM_W'(dw_q) + NUM_W'(in_data_i.dst_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      num1_q  <= NUM_W'(in_data_i.dst_y) * NUM_W'(sh_q);
      xs1_q   <= XS_W'(in_data_i.dst_x) * XS_W'(step);
      word1_q <= word_full[WORD_W-1:0];
      yin1_q  <= {1'b0, in_data_i.dst_y} < dh_q;
    end
  end

  // Stage 2: column accumulate and clamp
  logic               v2_q;
  logic [COORD_W-1:0] col2_q;
  logic [NUM_W-1:0]   num2_q;
  logic [WORD_W-1:0]  word2_q;
  logic               yin2_q;
  logic [ACC_W-1:0]   acc;
  logic [COLR_W-1:0]  col_raw;
  logic [COORD_W-1:0] col_sat;

  assign rdy2    = !v2_q || div_rdy;
  assign acc     = ACC_W'(col_start) + ACC_W'(xs1_q);
  assign col_raw = acc[ACC_W-1:FRAC_BITS];
  assign col_sat = (col_raw > COLR_W'(sw_last)) ? sw_last[COORD_W-1:0]
                                                : col_raw[COORD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      col2_q  <= col_sat;
      num2_q  <= num1_q;
      word2_q <= word1_q;
      yin2_q  <= yin1_q;
    end
  end

  // Row divider: dst_y * src_height / dst_height
  logic               div_valid;
  logic [COORD_W-1:0] div_quot;
  row_side_t          div_side_in, div_side;

  assign div_side_in = '{col: col2_q, word: word2_q, y_in: yin2_q};

  nnsa_row_div u_row_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v2_q),
    .ready_o  (div_rdy),
    .num_i    (num2_q),
    .side_i   (div_side_in),
    .divisor_i(dh_q),
    .valid_o  (div_valid),
    .ready_i  (rdy3),
    .quot_o   (div_quot),
    .side_o   (div_side)
  );

  // Stage 3: row select and row times source width
  logic               v3_q;
  logic [COORD_W-1:0] row3_q, col3_q;
  logic [NUM_W-1:0]   prod3_q;
  logic [WORD_W-1:0]  word3_q;
  logic [COORD_W-1:0] row_sel;

  // rows beyond the destination clamp to the last source row
  assign rdy3    = !v3_q || rdy4;
  assign row_sel = div_side.y_in ? div_quot : sh_last[COORD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      row3_q  <= row_sel;
      col3_q  <= div_side.col;
      prod3_q <= NUM_W'(row_sel) * NUM_W'(sw_q);
      word3_q <= div_side.word;
    end
  end

  // Stage 4: byte offset, three bytes per source pixel, into the output register
  logic                  out_v_q;
  pix_out_t              out_q;
  logic [SUM_W-1:0]      pix_sum;
  logic [OFS_FULL_W-1:0] ofs_full;

  assign rdy4     = !out_v_q || !out_stall_i;
  assign pix_sum  = SUM_W'(prod3_q) + SUM_W'(col3_q);
  assign ofs_full = (OFS_FULL_W'(pix_sum) << 1) + OFS_FULL_W'(pix_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (rdy4) begin
      out_v_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      out_q.src_col         <= col3_q;
      out_q.src_row         <= row3_q;
      out_q.src_byte_offset <= ofs_full[OFS_W-1:0];
      out_q.dst_word_index  <= word3_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule
